// ===== rtl/core/rdz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdz_pkg
// Shared types and constants for the radial dead-zone stick scaler core.
// ----------------------------------------------------------------------------
package rdz_pkg;

	// Full-scale axis value and output saturation limit
	localparam int unsigned AXIS_MAX   = 32767;
	localparam int unsigned FULL_SCALE = 32767;
	localparam logic [14:0] RADIUS_RST = 15'd7849;

	// Magnitude with 8 fraction bits and the square-root remainder width
	localparam int MAG_W    = 24;
	localparam int SQ_REM_W = 26;
	localparam int SQ_STEPS = 24;
	// Clamped magnitude limit, AXIS_MAX with 8 fraction bits
	localparam logic [22:0] MAG_TOP = 23'(AXIS_MAX << 8);

	// Norm divider: 23-bit divisor, 16 quotient bits
	localparam int N_RW    = 23;
	localparam int N_QW    = 16;
	// Axis divider: 24-bit divisor, 15 quotient bits
	localparam int A_RW    = 24;
	localparam int A_QW    = 15;
	localparam int P_LO_W  = 7;

	typedef struct packed {
		logic signed [15:0] stick_x;
		logic signed [15:0] stick_y;
	} stick_in_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic [14:0]        norm_magnitude;
		logic               in_dead_zone;
	} stick_out_t;

	// Sideband through the square-root cells
	typedef struct packed {
		logic               sx;
		logic               sy;
		logic [15:0]        ax;
		logic [15:0]        ay;
		logic [14:0]        dz;
		logic               dead;
		logic [31:0]        sq;
	} sqrt_side_t;

	// Sideband through the norm divider cells
	typedef struct packed {
		logic               sx;
		logic               sy;
		logic [15:0]        ax;
		logic [15:0]        ay;
		logic [MAG_W-1:0]   mag8;
		logic               dead;
		logic               act;
	} norm_side_t;

	// Sideband through the x-axis divider lane
	typedef struct packed {
		logic               sx;
		logic               dead;
		logic [14:0]        norm;
		logic [P_LO_W-1:0]  plo;
	} xlane_side_t;

	// Sideband through the y-axis divider lane
	typedef struct packed {
		logic               sy;
		logic [P_LO_W-1:0]  plo;
	} ylane_side_t;

endpackage

// ===== rtl/core/rdz_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdz_sqrt_cell
// One digit-by-digit square-root step: takes one bit pair, yields one root bit.
// ----------------------------------------------------------------------------
module rdz_sqrt_cell #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vld_in,
	input  logic [1:0]                   pair_in,
	input  logic [rdz_pkg::MAG_W-1:0]    root_in,
	input  logic [rdz_pkg::SQ_REM_W-1:0] rem_in,
	input  logic [SIDE_W-1:0]            side_in,
	output logic                         vld_out,
	output logic [rdz_pkg::MAG_W-1:0]    root_out,
	output logic [rdz_pkg::SQ_REM_W-1:0] rem_out,
	output logic [SIDE_W-1:0]            side_out
);
	import rdz_pkg::*;

	logic [SQ_REM_W+1:0] rem_sh;
	logic [SQ_REM_W+1:0] trial;
	logic                ge;
	logic [SQ_REM_W+1:0] rem_nx;

	// Try to subtract (4*root + 1) from the shifted remainder
	always_comb begin
		rem_sh = {rem_in, pair_in};
		trial  = {2'b00, root_in, 2'b01};
		ge     = rem_sh >= trial;
		rem_nx = ge ? rem_sh - trial : rem_sh;
	end

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	// Hand the partial root on to the next cell
	always_ff @(posedge clk) begin
		root_out <= {root_in[MAG_W-2:0], ge};
		rem_out  <= rem_nx[SQ_REM_W-1:0];
		side_out <= side_in;
	end

endmodule

// ===== rtl/core/rdz_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdz_div_cell
// One restoring-division step: shift in one dividend bit, yield one quotient bit.
// ----------------------------------------------------------------------------
module rdz_div_cell #(
	parameter int RW     = 23,
	parameter int QW     = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  logic              bit_in,
	input  logic [RW-1:0]     rem_in,
	input  logic [RW-1:0]     div_in,
	input  logic [QW-1:0]     quo_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [RW-1:0]     rem_out,
	output logic [RW-1:0]     div_out,
	output logic [QW-1:0]     quo_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [RW:0] trial;
	logic        ge;
	logic [RW:0] diff;

	// Compare the shifted remainder with the divisor
	always_comb begin
		trial = {rem_in, bit_in};
		ge    = trial >= {1'b0, div_in};
		diff  = trial - {1'b0, div_in};
	end

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	// Hand the partial quotient on to the next cell
	always_ff @(posedge clk) begin
		rem_out  <= ge ? diff[RW-1:0] : trial[RW-1:0];
		div_out  <= div_in;
		quo_out  <= {quo_in[QW-2:0], ge};
		side_out <= side_in;
	end

endmodule

// ===== rtl/core/radial_dead_zone_stick_scaler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_dead_zone_stick_scaler_core
// Circular dead zone and Q1.15 direction scaling of a thumbstick sample.
// ----------------------------------------------------------------------------
// Channel   Signals                     Handshake
// input     start, busy, item           taken when start=1 and busy=0
// result    done, result                one-cycle strobe, no back-pressure
// config    cfg_we, cfg_wdata           dead-zone radius, written when cfg_we=1
//
// One item per clock; busy is held low. Each item passes through 3 squaring
// stages, 24 square-root cells, 16 norm divider cells, 15 axis divider cells
// and the scaling and output stages.
// Reset clears the valid chain and loads the radius with 7849.
// ----------------------------------------------------------------------------
module radial_dead_zone_stick_scaler_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rdz_pkg::stick_in_t item,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_wdata,
	output logic               done,
	output rdz_pkg::stick_out_t result
);
	import rdz_pkg::*;

	logic [14:0] dz_q;

	logic               vld_s1;
	logic signed [15:0] x_s1, y_s1;
	logic [14:0]        dz_s1;

	logic               vld_s2;
	logic [30:0]        xx_s2, yy_s2;
	logic [29:0]        dz2_s2;
	logic signed [15:0] x_s2, y_s2;
	logic [14:0]        dz_s2;

	logic               vld_s3;
	sqrt_side_t         side_s3;

	logic                  sq_vld  [0:SQ_STEPS];
	logic [MAG_W-1:0]      sq_root [0:SQ_STEPS];
	logic [SQ_REM_W-1:0]   sq_rem  [0:SQ_STEPS];
	sqrt_side_t            sq_side [0:SQ_STEPS];

	logic [MAG_W-1:0]  mag8;
	logic [22:0]       clamp;
	logic [22:0]       dz8;
	logic              act;
	sqrt_side_t        sq_end;

	logic              vld_s4;
	logic [N_RW-1:0]   n_s4;
	logic [N_RW-1:0]   den_s4;
	norm_side_t        side_s4;

	logic              nd_vld  [0:N_QW];
	logic [N_RW-1:0]   nd_rem  [0:N_QW];
	logic [N_RW-1:0]   nd_div  [0:N_QW];
	logic [N_QW-1:0]   nd_quo  [0:N_QW];
	norm_side_t        nd_side [0:N_QW];

	norm_side_t        nd_end;
	logic [14:0]       norm;

	logic              vld_s5;
	logic [30:0]       px_s5, py_s5;
	logic [A_RW-1:0]   mdiv_s5;
	logic              sx_s5, sy_s5, dead_s5;
	logic [14:0]       norm_s5;

	logic              xd_vld  [0:A_QW];
	logic [A_RW-1:0]   xd_rem  [0:A_QW];
	logic [A_RW-1:0]   xd_div  [0:A_QW];
	logic [A_QW-1:0]   xd_quo  [0:A_QW];
	xlane_side_t       xd_side [0:A_QW];

	logic              yd_vld  [0:A_QW];
	logic [A_RW-1:0]   yd_rem  [0:A_QW];
	logic [A_RW-1:0]   yd_div  [0:A_QW];
	logic [A_QW-1:0]   yd_quo  [0:A_QW];
	ylane_side_t       yd_side [0:A_QW];

	xlane_side_t       xd_end;
	ylane_side_t       yd_end;

	assign busy = 1'b0;

	// Hold the dead-zone radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= RADIUS_RST;
		end else if (cfg_we) begin
			dz_q <= cfg_wdata;
		end
	end

	// Valid bits of the registered stages outside the cell chains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= sq_vld[SQ_STEPS];
			vld_s5 <= nd_vld[N_QW];
			done   <= xd_vld[A_QW];
		end
	end

	// Capture the item, square the axes and the radius, then sum and test
	always_ff @(posedge clk) begin
		x_s1  <= item.stick_x;
		y_s1  <= item.stick_y;
		dz_s1 <= dz_q;

		xx_s2  <= 31'(32'(x_s1) * 32'(x_s1));
		yy_s2  <= 31'(32'(y_s1) * 32'(y_s1));
		dz2_s2 <= dz_s1 * dz_s1;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		dz_s2  <= dz_s1;

		side_s3.sx   <= x_s2[15];
		side_s3.sy   <= (y_s2 > 16'sd0);
		side_s3.ax   <= x_s2[15] ? 16'(-x_s2) : x_s2;
		side_s3.ay   <= y_s2[15] ? 16'(-y_s2) : y_s2;
		side_s3.dz   <= dz_s2;
		side_s3.dead <= ({1'b0, xx_s2} + {1'b0, yy_s2}) <= {2'b00, dz2_s2};
		side_s3.sq   <= {1'b0, xx_s2} + {1'b0, yy_s2};
	end

	// Square-root chain over (x*x + y*y) << 16
	assign sq_vld[0]  = vld_s3;
	assign sq_root[0] = '0;
	assign sq_rem[0]  = '0;
	assign sq_side[0] = side_s3;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		localparam int P = SQ_STEPS - 1 - i;
		logic [47:0] v;
		assign v = {sq_side[i].sq, 16'h0000};
		rdz_sqrt_cell #(
			.SIDE_W($bits(sqrt_side_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (sq_vld[i]),
			.pair_in  (v[2*P+1:2*P]),
			.root_in  (sq_root[i]),
			.rem_in   (sq_rem[i]),
			.side_in  (sq_side[i]),
			.vld_out  (sq_vld[i+1]),
			.root_out (sq_root[i+1]),
			.rem_out  (sq_rem[i+1]),
			.side_out (sq_side[i+1])
		);
	end

	// Clamp the magnitude and subtract the radius
	always_comb begin
		sq_end = sq_side[SQ_STEPS];
		mag8   = sq_root[SQ_STEPS];
		clamp  = (mag8 > {1'b0, MAG_TOP}) ? MAG_TOP : mag8[22:0];
		dz8    = {sq_end.dz, 8'h00};
		act    = !sq_end.dead && (clamp > dz8);
	end

	always_ff @(posedge clk) begin
		n_s4         <= act ? clamp - dz8 : '0;
		den_s4       <= act ? {15'(AXIS_MAX) - sq_end.dz, 8'h00} : N_RW'(1);
		side_s4.sx   <= sq_end.sx;
		side_s4.sy   <= sq_end.sy;
		side_s4.ax   <= sq_end.ax;
		side_s4.ay   <= sq_end.ay;
		side_s4.mag8 <= mag8;
		side_s4.dead <= sq_end.dead;
		side_s4.act  <= act;
	end

	// Norm divider chain: (n << 15) / den
	assign nd_vld[0]  = vld_s4;
	assign nd_rem[0]  = {1'b0, n_s4[N_RW-1:1]};
	assign nd_div[0]  = den_s4;
	assign nd_quo[0]  = '0;
	assign nd_side[0] = side_s4;

	for (genvar i = 0; i < N_QW; i++) begin : g_norm
		rdz_div_cell #(
			.RW(N_RW), .QW(N_QW), .SIDE_W($bits(norm_side_t))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (nd_vld[i]),
			.bit_in   ((i == 0) ? n_s4[0] : 1'b0),
			.rem_in   (nd_rem[i]),
			.div_in   (nd_div[i]),
			.quo_in   (nd_quo[i]),
			.side_in  (nd_side[i]),
			.vld_out  (nd_vld[i+1]),
			.rem_out  (nd_rem[i+1]),
			.div_out  (nd_div[i+1]),
			.quo_out  (nd_quo[i+1]),
			.side_out (nd_side[i+1])
		);
	end

	// Saturate the norm and scale each axis by it
	always_comb begin
		nd_end = nd_side[N_QW];
		norm   = (nd_quo[N_QW] > N_QW'(FULL_SCALE)) ? 15'(FULL_SCALE)
			: nd_quo[N_QW][14:0];
	end

	always_ff @(posedge clk) begin
		px_s5   <= nd_end.ax * norm;
		py_s5   <= nd_end.ay * norm;
		mdiv_s5 <= nd_end.act ? nd_end.mag8 : A_RW'(1);
		sx_s5   <= nd_end.sx;
		sy_s5   <= nd_end.sy;
		dead_s5 <= nd_end.dead;
		norm_s5 <= norm;
	end

	// Axis divider lanes: (|a| * norm << 8) / mag8
	assign xd_vld[0]       = vld_s5;
	assign xd_rem[0]       = px_s5[30:P_LO_W];
	assign xd_div[0]       = mdiv_s5;
	assign xd_quo[0]       = '0;
	assign xd_side[0].sx   = sx_s5;
	assign xd_side[0].dead = dead_s5;
	assign xd_side[0].norm = norm_s5;
	assign xd_side[0].plo  = px_s5[P_LO_W-1:0];

	assign yd_vld[0]      = vld_s5;
	assign yd_rem[0]      = py_s5[30:P_LO_W];
	assign yd_div[0]      = mdiv_s5;
	assign yd_quo[0]      = '0;
	assign yd_side[0].sy  = sy_s5;
	assign yd_side[0].plo = py_s5[P_LO_W-1:0];

	for (genvar i = 0; i < A_QW; i++) begin : g_axis
		localparam int B = A_QW - 1 - i;
		logic xb, yb;
		if (B >= 8) begin : g_data
			assign xb = xd_side[i].plo[B-8];
			assign yb = yd_side[i].plo[B-8];
		end else begin : g_zero
			assign xb = 1'b0;
			assign yb = 1'b0;
		end

		rdz_div_cell #(
			.RW(A_RW), .QW(A_QW), .SIDE_W($bits(xlane_side_t))
		) u_xcell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (xd_vld[i]),
			.bit_in   (xb),
			.rem_in   (xd_rem[i]),
			.div_in   (xd_div[i]),
			.quo_in   (xd_quo[i]),
			.side_in  (xd_side[i]),
			.vld_out  (xd_vld[i+1]),
			.rem_out  (xd_rem[i+1]),
			.div_out  (xd_div[i+1]),
			.quo_out  (xd_quo[i+1]),
			.side_out (xd_side[i+1])
		);

		rdz_div_cell #(
			.RW(A_RW), .QW(A_QW), .SIDE_W($bits(ylane_side_t))
		) u_ycell (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (yd_vld[i]),
			.bit_in   (yb),
			.rem_in   (yd_rem[i]),
			.div_in   (yd_div[i]),
			.quo_in   (yd_quo[i]),
			.side_in  (yd_side[i]),
			.vld_out  (yd_vld[i+1]),
			.rem_out  (yd_rem[i+1]),
			.div_out  (yd_div[i+1]),
			.quo_out  (yd_quo[i+1]),
			.side_out (yd_side[i+1])
		);
	end

	// Apply the signs and register the result item
	always_comb begin
		xd_end = xd_side[A_QW];
		yd_end = yd_side[A_QW];
	end

	always_ff @(posedge clk) begin
		result.dir_x <= xd_end.sx ? -$signed({1'b0, xd_quo[A_QW]})
			: $signed({1'b0, xd_quo[A_QW]});
		result.dir_y <= yd_end.sy ? -$signed({1'b0, yd_quo[A_QW]})
			: $signed({1'b0, yd_quo[A_QW]});
		result.norm_magnitude <= xd_end.norm;
		result.in_dead_zone   <= xd_end.dead;
	end

endmodule

// ===== tb/radial_dead_zone_stick_scaler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_dead_zone_stick_scaler_core_tb
// Checks the radial dead-zone scaler against a bit-exact predictor. Directed
// samples (centre, axis extremes, dead-zone edge, radius extremes) run first,
// then random samples at several radius settings, most with random start gaps.
// Every result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module radial_dead_zone_stick_scaler_core_tb;
	import rdz_pkg::*;

	localparam int LATENCY   = 61;
	localparam int CYCLE_CAP = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	stick_in_t  item = '0;
	logic       cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic       done;
	stick_out_t result;

	logic [14:0] radius_q = RADIUS_RST;
	stick_out_t  scaled_q[$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;

	radial_dead_zone_stick_scaler_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .result(result)
	);

	always #6 clk = ~clk;

	// Integer square root, bit by bit
	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] scale_dir(longint a, longint unsigned nrm,
			longint unsigned m8);
		longint unsigned q;
		q = ((a < 0 ? -a : a) * 256 * nrm) / m8;
		if (q > FULL_SCALE) q = FULL_SCALE;
		return a < 0 ? 16'(-longint'(q)) : 16'(q);
	endfunction

	function automatic stick_out_t scale_stick(stick_in_t s, logic [14:0] dz);
		stick_out_t o;
		longint x, y;
		longint unsigned sq, m8, c, nrm;
		o = '0;
		x = s.stick_x;
		y = s.stick_y;
		sq = x * x + y * y;
		if (sq <= longint'(dz) * dz) begin
			o.in_dead_zone = 1'b1;
		end else begin
			m8 = root64(sq << 16);
			c = m8 > (AXIS_MAX << 8) ? (AXIS_MAX << 8) : m8;
			if (c > (longint'(dz) << 8)) begin
				nrm = ((c - (longint'(dz) << 8)) << 15) / ((AXIS_MAX - dz) << 8);
				if (nrm > FULL_SCALE) nrm = FULL_SCALE;
				o.norm_magnitude = 15'(nrm);
				o.dir_x = scale_dir(x, nrm, m8);
				o.dir_y = scale_dir(-y, nrm, m8);
			end
		end
		return o;
	endfunction

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		stick_out_t e;
		cycles <= cycles + 1;
		if (done) begin
			if (scaled_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				e = scaled_q.pop_front();
				if (result !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp dx=%0d dy=%0d n=%0d d=%0b got dx=%0d dy=%0d n=%0d d=%0b",
							e.dir_x, e.dir_y, e.norm_magnitude, e.in_dead_zone,
							result.dir_x, result.dir_y, result.norm_magnitude,
							result.in_dead_zone);
				end
			end
		end
		if (cycles > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Send one item, with an optional random gap before it
	task automatic send_stick(logic [15:0] x, logic [15:0] y);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		start <= 1'b1;
		item <= {x, y};
		@(posedge clk);
		while (busy) @(posedge clk);
		scaled_q.push_back(scale_stick({x, y}, radius_q));
		@(negedge clk);
	endtask

	// Drain, then write the radius while idle
	task automatic set_radius(logic [14:0] r);
		start <= 1'b0;
		@(negedge clk);
		while (scaled_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
		radius_q = r;
	endtask

	task automatic test_directed();
		send_stick(16'sd0, 16'sd0);
		send_stick(16'sd32767, 16'sd0);
		send_stick(-16'sd32768, 16'sd0);
		send_stick(16'sd0, 16'sd32767);
		send_stick(16'sd0, -16'sd32768);
		send_stick(-16'sd32768, -16'sd32768);
		send_stick(16'sd32767, 16'sd32767);
		send_stick(16'sd7849, 16'sd0);
		send_stick(16'sd7850, 16'sd0);
		send_stick(16'sd0, -16'sd7849);
		send_stick(16'hFFFF, 16'h0001);
		send_stick(16'h5555, 16'hAAAA);
		send_stick(16'hAAAA, 16'h5555);
	endtask

	task automatic test_radius_extremes();
		set_radius(15'd0);
		send_stick(16'sd0, 16'sd0);
		send_stick(16'sd1, 16'sd0);
		send_stick(-16'sd1, -16'sd1);
		send_stick(-16'sd32768, 16'sd32767);
		set_radius(15'd32766);
		send_stick(16'sd32766, 16'sd0);
		send_stick(16'sd32767, 16'sd0);
		send_stick(-16'sd32768, -16'sd32768);
		set_radius(15'h7FFF);
		send_stick(-16'sd32768, 16'sd0);
		send_stick(16'sd32767, 16'sd32767);
	endtask

	task automatic test_random(logic [14:0] r, int n);
		logic [15:0] x, y;
		set_radius(r);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: begin
					x = 16'($urandom_range(0, 2 * r + 2) - r - 1);
					y = 16'($urandom_range(0, 2 * r + 2) - r - 1);
				end
				1: begin
					x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
					y = 16'($urandom);
				end
				default: begin
					x = 16'($urandom);
					y = 16'($urandom);
				end
			endcase
			send_stick(x, y);
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_radius_extremes();
		test_random(15'd7849, 150);
		test_random(15'd0, 100);
		test_random(15'($urandom_range(1, 32765)), 150);
		test_random(15'd32766, 60);
		quiet = 1'b1;
		test_random(15'($urandom_range(100, 20000)), 140);
		start <= 1'b0;
		while (scaled_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (mismatches == 0 && scaled_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rdz_pkg.sv
rtl/core/rdz_sqrt_cell.sv
rtl/core/rdz_div_cell.sv
rtl/core/radial_dead_zone_stick_scaler_core.sv
tb/radial_dead_zone_stick_scaler_core_tb.sv
